>>> rtl/hill_pkg.sv
// Shared constants, register indexes and helper functions of the 2x2 Hill cipher.
package hill_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ASCII_W  = 7;

  localparam logic [LETTER_W-1:0] LETTERS    = 5'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
  localparam logic [ASCII_W-1:0]  ASCII_A    = 7'd97;

  // Reduction of a value below 1024 by 26 uses floor(v * 78 / 2048), which is
  // either the true quotient or one below it.
  localparam logic [15:0] MOD26_RECIP = 16'd78;
  localparam int unsigned MOD26_SHIFT = 11;

  // Configuration register indexes (byte address / 4).
  localparam logic [2:0] REG_KEY_R0C0     = 3'd0;
  localparam logic [2:0] REG_KEY_R0C1     = 3'd1;
  localparam logic [2:0] REG_KEY_R1C0     = 3'd2;
  localparam logic [2:0] REG_KEY_R1C1     = 3'd3;
  localparam logic [2:0] REG_DECRYPT_MODE = 3'd4;

  // Brings a 5-bit key entry into 0..25.
  function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] k);
    red26 = (k >= LETTERS) ? k - LETTERS : k;
  endfunction

  // Additive inverse mod 26 of a value already in 0..25.
  function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] k);
    neg26 = (k == '0) ? '0 : LETTERS - k;
  endfunction

  // Multiplicative inverse mod 26; zero when none exists.
  function automatic logic [LETTER_W-1:0] inv_mod26(input logic [LETTER_W-1:0] det);
    case (det)
      5'd1:    inv_mod26 = 5'd1;
      5'd3:    inv_mod26 = 5'd9;
      5'd5:    inv_mod26 = 5'd21;
      5'd7:    inv_mod26 = 5'd15;
      5'd9:    inv_mod26 = 5'd3;
      5'd11:   inv_mod26 = 5'd19;
      5'd15:   inv_mod26 = 5'd7;
      5'd17:   inv_mod26 = 5'd23;
      5'd19:   inv_mod26 = 5'd11;
      5'd21:   inv_mod26 = 5'd5;
      5'd23:   inv_mod26 = 5'd17;
      5'd25:   inv_mod26 = 5'd25;
      default: inv_mod26 = 5'd0;
    endcase
  endfunction

endpackage

>>> rtl/hill_in_if.sv
// Input text channel: one text byte per request with its end-of-text mark.
interface hill_in_if import hill_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

>>> rtl/hill_out_if.sv
// Output letter channel: one result letter per request with its status flags.
interface hill_out_if import hill_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ASCII_W-1:0] letter_out;
  logic               pair_last;
  logic               key_error;

  modport source (output valid, output letter_out, output pair_last, output key_error,
                  input ready);
  modport sink   (input valid, input letter_out, input pair_last, input key_error,
                  output ready);
endinterface

>>> rtl/hill_cipher_2x2_mod26.sv
// Top level of the 2x2 Hill cipher over the lowercase alphabet.
//
// Text bytes arrive as requests on in_ch; 'a'..'z' become letters 0..25 and
// any other byte becomes letter 0. The first letter of a pair is held. The
// second one (or end_of_text on a first letter, which pads the pair with 'x')
// starts the pair computation, and two result letters leave on out_ch, the
// second one with pair_last set when the pair closed the message.
// The key and the decrypt mode are written through the APB port at byte
// addresses 0, 4, 8, 12 and 16; they must only change while the block idles.
// All arithmetic runs on one shared multiply-add-reduce-mod-26 unit under a
// small sequencer, one operation per cycle. After the request that completes
// it, an encrypt pair takes two multiply-adds and one output load per letter;
// a decrypt pair adds two determinant steps and one scaling multiply per
// letter. A request holding only a first letter leaves the block idle and
// ready; in_ch.ready is low while a pair is being computed.
// Results go through a one-entry output register, so a stalled receiver only
// holds the sequencer at its output load step; the block takes the next byte
// as soon as the second letter is loaded, even if it has not been taken yet.
// Reset restores the identity key, encrypt mode and an empty pair buffer.
module hill_cipher_2x2_mod26 import hill_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hill_in_if.sink     in_ch,
  hill_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DET0  = 3'd1;
  localparam logic [2:0] ST_DET1  = 3'd2;
  localparam logic [2:0] ST_ROW_A = 3'd3;
  localparam logic [2:0] ST_ROW_B = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_PUT   = 3'd6;

  // Configuration registers.
  logic [LETTER_W-1:0] key_r0c0_q, key_r0c1_q, key_r1c0_q, key_r1c1_q;
  logic                decrypt_mode_q;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_r0c0_q     <= 5'd1;
      key_r0c1_q     <= 5'd0;
      key_r1c0_q     <= 5'd0;
      key_r1c1_q     <= 5'd1;
      decrypt_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_R0C0:     key_r0c0_q     <= pwdata[LETTER_W-1:0];
        REG_KEY_R0C1:     key_r0c1_q     <= pwdata[LETTER_W-1:0];
        REG_KEY_R1C0:     key_r1c0_q     <= pwdata[LETTER_W-1:0];
        REG_KEY_R1C1:     key_r1c1_q     <= pwdata[LETTER_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_KEY_R0C0:     prdata = 32'(key_r0c0_q);
      REG_KEY_R0C1:     prdata = 32'(key_r0c1_q);
      REG_KEY_R1C0:     prdata = 32'(key_r1c0_q);
      REG_KEY_R1C1:     prdata = 32'(key_r1c1_q);
      REG_DECRYPT_MODE: prdata = 32'(decrypt_mode_q);
      default:          prdata = '0;
    endcase
  end

  // Key entries reduced into 0..25, and the negated off-diagonal entries
  // that the adjugate needs.
  logic [LETTER_W-1:0] ka, kb, kc, kd, nb, nc;
  assign ka = red26(key_r0c0_q);
  assign kb = red26(key_r0c1_q);
  assign kc = red26(key_r1c0_q);
  assign kd = red26(key_r1c1_q);
  assign nb = neg26(kb);
  assign nc = neg26(kc);

  // Sequencer state.
  logic [2:0]          state_q, state_d;
  logic                row_q, row_d;
  logic                err_q, err_d;
  logic                last_q, last_d;
  logic [LETTER_W-1:0] p0_q, p0_d, p1_q, p1_d;
  logic [LETTER_W-1:0] acc_q, acc_d;
  logic [LETTER_W-1:0] inv_q, inv_d;
  logic [LETTER_W-1:0] held_q, held_d;
  logic                have_first_q, have_first_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [ASCII_W-1:0]  letter_q, letter_d;
  logic                pair_last_q, pair_last_d;
  logic                key_error_q, key_error_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ch.ready;

  // Input letter value.
  logic                in_acc;
  logic                is_lower;
  logic [CHAR_W-1:0]   ch_off;
  logic [LETTER_W-1:0] in_letter;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ch_off      = in_ch.char_in - CHAR_W'(ASCII_A);
  assign is_lower    = (in_ch.char_in >= CHAR_W'(ASCII_A)) &&
                       (ch_off < CHAR_W'(LETTERS));
  assign in_letter   = is_lower ? ch_off[LETTER_W-1:0] : '0;

  // Shared unit: (x * y + addend) mod 26, with operands picked by the step.
  logic [LETTER_W-1:0] mul_x, mul_y, unit_res;
  logic                add_en;
  logic [9:0]          prod, sum, rem;
  logic [15:0]         scaled;
  logic [LETTER_W-1:0] quot;

  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    add_en = 1'b0;
    case (state_q)
      ST_DET0: begin
        mul_x = ka;
        mul_y = kd;
      end
      ST_DET1: begin
        mul_x  = nb;
        mul_y  = kc;
        add_en = 1'b1;
      end
      ST_ROW_A: begin
        if (decrypt_mode_q) begin
          mul_x = row_q ? nc : kd;
        end else begin
          mul_x = row_q ? kc : ka;
        end
        mul_y = p0_q;
      end
      ST_ROW_B: begin
        if (decrypt_mode_q) begin
          mul_x = row_q ? ka : nb;
        end else begin
          mul_x = row_q ? kd : kb;
        end
        mul_y  = p1_q;
        add_en = 1'b1;
      end
      ST_SCALE: begin
        mul_x = acc_q;
        mul_y = inv_q;
      end
      default: ;
    endcase
  end

  // The sum stays below 651, so the estimated quotient is at most one short
  // and a single compare and subtract finishes the reduction.
  assign prod     = 10'(mul_x) * 10'(mul_y);
  assign sum      = prod + (add_en ? 10'(acc_q) : 10'd0);
  assign scaled   = 16'(sum) * MOD26_RECIP;
  assign quot     = scaled[MOD26_SHIFT +: LETTER_W];
  assign rem      = sum - 10'(quot) * 10'(LETTERS);
  assign unit_res = (rem >= 10'(LETTERS)) ? LETTER_W'(rem - 10'(LETTERS)) : rem[LETTER_W-1:0];

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    err_d        = err_q;
    last_d       = last_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    acc_d        = acc_q;
    inv_d        = inv_q;
    held_d       = held_q;
    have_first_d = have_first_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    letter_d     = letter_q;
    pair_last_d  = pair_last_q;
    key_error_d  = key_error_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!have_first_q && !in_ch.end_of_text) begin
            held_d       = in_letter;
            have_first_d = 1'b1;
          end else begin
            // A pair is complete; an odd final letter is padded with 'x'.
            p0_d         = have_first_q ? held_q : in_letter;
            p1_d         = have_first_q ? in_letter : PAD_LETTER;
            last_d       = in_ch.end_of_text;
            held_d       = '0;
            have_first_d = 1'b0;
            row_d        = 1'b0;
            err_d        = 1'b0;
            state_d      = decrypt_mode_q ? ST_DET0 : ST_ROW_A;
          end
        end
      end
      ST_DET0: begin
        acc_d   = unit_res;
        state_d = ST_DET1;
      end
      ST_DET1: begin
        inv_d = inv_mod26(unit_res);
        if (inv_mod26(unit_res) == '0) begin
          err_d   = 1'b1;
          state_d = ST_PUT;
        end else begin
          state_d = ST_ROW_A;
        end
      end
      ST_ROW_A: begin
        acc_d   = unit_res;
        state_d = ST_ROW_B;
      end
      ST_ROW_B: begin
        acc_d   = unit_res;
        state_d = decrypt_mode_q ? ST_SCALE : ST_PUT;
      end
      ST_SCALE: begin
        acc_d   = unit_res;
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          letter_d    = err_q ? ASCII_A : ASCII_W'(acc_q) + ASCII_A;
          pair_last_d = row_q && last_q;
          key_error_d = err_q;
          if (!row_q) begin
            row_d   = 1'b1;
            state_d = err_q ? ST_PUT : ST_ROW_A;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= 1'b0;
      err_q        <= 1'b0;
      held_q       <= '0;
      have_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      err_q        <= err_d;
      held_q       <= held_d;
      have_first_q <= have_first_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    p0_q        <= p0_d;
    p1_q        <= p1_d;
    acc_q       <= acc_d;
    inv_q       <= inv_d;
    letter_q    <= letter_d;
    pair_last_q <= pair_last_d;
    key_error_q <= key_error_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.letter_out = letter_q;
  assign out_ch.pair_last  = pair_last_q;
  assign out_ch.key_error  = key_error_q;

endmodule

>>> rtl/hill_chk.sv
// Port-level checker for the Hill cipher top level, with its bind statement.
module hill_chk import hill_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               end_of_text,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ASCII_W-1:0] letter_out,
  input logic               key_error
);

  // A result waiting for the receiver keeps its letter.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(letter_out))
    else $error("stalled result changed");

  // Every result letter is a lowercase ASCII letter.
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (letter_out >= ASCII_A) && (letter_out <= ASCII_A + 7'd25))
    else $error("result letter out of range");

  // A bad decrypt key always yields the letter 'a'.
  a_err_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && key_error |-> letter_out == ASCII_A)
    else $error("key error with a letter other than a");

  // A byte that closes the message starts a pair, so the block is busy next.
  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && end_of_text |=> !in_ready)
    else $error("ready right after a final byte");

endmodule

bind hill_cipher_2x2_mod26 hill_chk u_hill_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .end_of_text (in_ch.end_of_text),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .letter_out  (out_ch.letter_out),
  .key_error   (out_ch.key_error)
);
